>>> hdl/com_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// com_pkg
// Shared types and fixed constants of the camera occlusion monitor.
// -----------------------------------------------------------------------------
package com_pkg;

   localparam int SCORE_W    = 32;
   localparam int TS_W       = 48;
   localparam int FC_W       = 32;
   localparam int RUN_W      = 16;
   localparam int LOW_W      = 40;
   localparam int SIGMA_W    = 12;
   localparam int ROOT_W     = 32;
   localparam int PROD_W     = SIGMA_W + ROOT_W;
   localparam int DIVISOR_W  = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int WINDOW_W   = 19;

   localparam logic [2:0] FIVE = 3'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CALIB_FRAMES     = 3'd0,
      CSR_SAMPLE_SPACING   = 3'd1,
      CSR_NORMAL_RUN_LIMIT = 3'd2,
      CSR_OCCL_RUN_LIMIT   = 3'd3,
      CSR_RECALIB_INTERVAL = 3'd4,
      CSR_INITIAL_LOW      = 3'd5,
      CSR_SIGMA            = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_MOD,
      S_SUM,
      S_MEAN,
      S_VAR,
      S_VDIV,
      S_SQRT,
      S_BOUND,
      S_UPDATE,
      S_OUT
   } state_type;

endpackage
`default_nettype wire

>>> hdl/com_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// com_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// -----------------------------------------------------------------------------
module com_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                            wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

>>> hdl/com_div.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// com_div
// Serial restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module com_div #(
   parameter int DV_W = 71,
   parameter int DS_W = 11
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [DV_W-1:0] dividend,
   input  wire logic [DS_W-1:0] divisor,
   output logic                 busy,
   output logic                 done,
   output logic      [DV_W-1:0] quotient,
   output logic      [DS_W-1:0] remainder
);
   localparam int CW = $clog2(DV_W + 1);

   logic [DV_W-1:0] quo_ff, quo_in;
   logic [DS_W-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [DS_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DV_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CW'(DV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DS_W'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[DV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DS_W-1:0];
            quo_in = {quo_ff[DV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

>>> hdl/com_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// com_sqrt
// Serial floor square root of a 64-bit value, one root bit per cycle.
// -----------------------------------------------------------------------------
module com_sqrt
   import com_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [2*ROOT_W-1:0] radicand,
   output logic                     done,
   output logic      [ROOT_W-1:0]   root
);
   localparam int CW = $clog2(ROOT_W + 1);

   logic [2*ROOT_W-1:0] x_ff, x_in;
   logic [ROOT_W+1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [ROOT_W+3:0]   r, trial;

   always_comb begin
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      r       = {rem_ff, x_ff[2*ROOT_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CW'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (r >= trial) begin
            rem_in  = (ROOT_W+2)'(r - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = r[ROOT_W+1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         x_in   = {x_ff[2*ROOT_W-3:0], 2'b00};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

>>> hdl/camera_occlusion_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// camera_occlusion_monitor
// Per-camera occlusion monitor with learned low sharpness bound.
//
// Usage: the req_ channel carries one item (command, camera, score, timestamp)
// per transfer and the rsp_ channel returns one occluded flag per item, in
// order. The csr_ channel writes the seven setup registers; csr_ready is
// always high and writes are expected only while the block is idle.
// Per-camera records live in a state RAM and kept scores in a sample RAM.
// An ordinary frame goes through the record lookup, the update and the output
// register. A frame on which a score may be kept runs the serial divider once.
// The learning frame walks the kept scores (up to MAX_SAMPLES) twice, runs the
// serial divider twice and runs the serial square root.
// One item is processed at a time; req_stall stays high until the result is
// in the output register, and the next item is taken while it waits.
// Reset clears all camera records at once through per-camera valid bits.
// While rsp_stall is high the result holds and the block waits after the
// item in progress.
// -----------------------------------------------------------------------------
module camera_occlusion_monitor
   import com_pkg::*;
#(
   parameter int NUM_CAMERAS = 16,
   parameter int MAX_SAMPLES = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_command,
   input  wire logic [3:0]            req_camera,
   input  wire logic [SCORE_W-1:0]    req_score,
   input  wire logic [TS_W-1:0]       req_timestamp,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_occluded,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int CAM_AW = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
   localparam int SMP_AW = $clog2(MAX_SAMPLES);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = SCORE_W + CNT_W;
   localparam int SQ_W   = 2 * SCORE_W;
   localparam int SS_W   = SQ_W + CNT_W;
   localparam int REC_W  = FC_W + TS_W + 2 * RUN_W + LOW_W + 1 + CNT_W;
   localparam int SMP_DEPTH = 1 << (CAM_AW + SMP_AW);

   typedef struct packed {
      logic [FC_W-1:0]  frame_count;
      logic [TS_W-1:0]  window_start;
      logic [RUN_W-1:0] normal_run;
      logic [RUN_W-1:0] low_run;
      logic [LOW_W-1:0] learned_low;
      logic             learned_valid;
      logic [CNT_W-1:0] kept_count;
   } cam_rec_type;

   // Setup registers.
   logic [15:0]         calib_ff, nlimit_ff, olimit_ff;
   logic [7:0]          spacing_ff;
   logic [31:0]         recalib_ff, initlow_ff;
   logic [SIGMA_W-1:0]  sigma_ff;

   state_type           state_ff, state_in;
   logic                cmd_ff, cmd_in;
   logic [3:0]          cam_ff, cam_in;
   logic [SCORE_W-1:0]  score_ff, score_in;
   logic [TS_W-1:0]     ts_ff, ts_in;
   cam_rec_type         rec_ff, rec_in, base;
   logic [NUM_CAMERAS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                rd_vld_ff, rd_vld_in, d_vld_ff, d_vld_in, sq_vld_ff, sq_vld_in;
   logic [SCORE_W-1:0]  d_ff, d_in, mean_ff, mean_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SS_W-1:0]     ss_ff, ss_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                occ_ff, occ_in;
   logic                rsp_valid_ff, rsp_valid_in, rsp_occ_ff, rsp_occ_in;

   // The record is written once it is final, on the cycle after S_UPDATE.
   logic wb_ff;

   logic [CAM_AW-1:0]   cam_addr, req_addr;
   logic                in_range;
   logic [WINDOW_W-1:0] window;
   logic [DIVISOR_W-1:0] spacing5;
   logic [FC_W-1:0]     window32;

   logic                st_we;
   logic [REC_W-1:0]    st_rdata;
   logic                smp_we;
   logic [CAM_AW+SMP_AW-1:0] smp_waddr, smp_raddr;
   logic [SCORE_W-1:0]  smp_rdata;

   logic                div_start, div_busy, div_done;
   logic [SS_W-1:0]     div_dividend, div_quo;
   logic [DIVISOR_W-1:0] div_divisor, div_rem;
   logic                sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]   sqrt_root;

   logic signed [PROD_W:0]  diff;
   logic signed [PROD_W:0]  diff_sh;
   logic signed [LOW_W:0]   bound, score_s;
   logic [TS_W-1:0]         delta;
   logic [8:0]              cam_wide, req_wide;

   assign cam_wide = {5'b0, cam_ff};
   assign req_wide = {5'b0, req_camera};
   assign cam_addr = cam_wide[CAM_AW-1:0];
   assign req_addr = req_wide[CAM_AW-1:0];
   assign in_range = cam_wide < 9'(NUM_CAMERAS);
   assign window   = {3'b0, calib_ff} * WINDOW_W'(FIVE);
   assign spacing5 = {3'b0, spacing_ff} * DIVISOR_W'(FIVE);
   assign window32 = FC_W'(window);

   com_ram #(.WIDTH(REC_W), .DEPTH(NUM_CAMERAS)) u_state_ram (
      .clock (clock),
      .we    (st_we),
      .waddr (cam_addr),
      .wdata (rec_ff),
      .raddr (req_addr),
      .rdata (st_rdata)
   );

   com_ram #(.WIDTH(SCORE_W), .DEPTH(SMP_DEPTH)) u_sample_ram (
      .clock (clock),
      .we    (smp_we),
      .waddr (smp_waddr),
      .wdata (score_ff),
      .raddr (smp_raddr),
      .rdata (smp_rdata)
   );

   com_div #(.DV_W(SS_W), .DS_W(DIVISOR_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   com_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (div_quo[SQ_W-1:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign smp_waddr = {cam_addr, rec_ff.kept_count[SMP_AW-1:0]};
   assign smp_raddr = {cam_addr, idx_ff[SMP_AW-1:0]};

   // Floor of the bound in signed Q36.8 units is an arithmetic shift.
   assign diff    = $signed({1'b0, {(PROD_W-SCORE_W-8){1'b0}}, mean_ff, 8'b0})
                    - $signed({1'b0, prod_ff});
   assign diff_sh = diff >>> 8;
   assign bound   = rec_ff.learned_valid ? $signed({rec_ff.learned_low[LOW_W-1],
                                                    rec_ff.learned_low})
                                         : $signed({{(LOW_W-31){1'b0}}, initlow_ff});
   assign score_s = $signed({{(LOW_W-SCORE_W+1){1'b0}}, score_ff});
   assign delta   = ts_ff - rec_ff.window_start;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cam_in       = cam_ff;
      score_in     = score_ff;
      ts_in        = ts_ff;
      rec_in       = rec_ff;
      valid_in     = valid_ff;
      idx_in       = idx_ff;
      rd_vld_in    = 1'b0;
      d_vld_in     = 1'b0;
      sq_vld_in    = 1'b0;
      d_in         = d_ff;
      sq_in        = sq_ff;
      sum_in       = sum_ff;
      ss_in        = ss_ff;
      mean_in      = mean_ff;
      prod_in      = prod_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_occ_in   = rsp_occ_ff;
      smp_we       = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      sqrt_start   = 1'b0;
      base         = valid_ff[cam_addr] ? cam_rec_type'(st_rdata) : '0;
      req_stall    = (state_ff != S_IDLE);
      if (wb_ff) begin
         valid_in[cam_addr] = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               cam_in   = req_camera;
               score_in = req_score;
               ts_in    = req_timestamp;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (!in_range) begin
               occ_in   = 1'b0;
               state_in = S_OUT;
            end else if (cmd_ff) begin
               valid_in[cam_addr] = 1'b0;
               occ_in   = 1'b0;
               state_in = S_OUT;
            end else begin
               rec_in = base;
               if (base.frame_count == '0) begin
                  rec_in.kept_count   = '0;
                  rec_in.window_start = ts_ff;
                  rec_in.low_run      = '0;
                  rec_in.normal_run   = '0;
               end
               if (base.frame_count != '1) begin
                  rec_in.frame_count = base.frame_count + FC_W'(1);
               end
               if (rec_in.frame_count <= window32 && spacing5 != '0) begin
                  div_start    = 1'b1;
                  div_dividend = SS_W'(rec_in.frame_count);
                  div_divisor  = spacing5;
                  state_in     = S_MOD;
               end else if (rec_in.frame_count == window32 + FC_W'(1)) begin
                  if (rec_in.kept_count != '0) begin
                     idx_in   = '0;
                     sum_in   = '0;
                     state_in = S_SUM;
                  end else begin
                     state_in = S_UPDATE;
                  end
               end else begin
                  state_in = S_UPDATE;
               end
            end
         end
         S_MOD: begin
            if (div_done) begin
               if (div_rem == '0 && rec_ff.kept_count < CNT_W'(MAX_SAMPLES)) begin
                  smp_we            = 1'b1;
                  rec_in.kept_count = rec_ff.kept_count + CNT_W'(1);
               end
               state_in = S_UPDATE;
            end
         end
         S_SUM: begin
            if (idx_ff < rec_ff.kept_count) begin
               idx_in    = idx_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               sum_in = sum_ff + SUM_W'(smp_rdata);
            end
            if (idx_ff == rec_ff.kept_count && !rd_vld_ff) begin
               div_start    = 1'b1;
               div_dividend = SS_W'(sum_ff);
               div_divisor  = DIVISOR_W'(rec_ff.kept_count);
               state_in     = S_MEAN;
            end
         end
         S_MEAN: begin
            if (div_done) begin
               mean_in  = div_quo[SCORE_W-1:0];
               idx_in   = '0;
               ss_in    = '0;
               state_in = S_VAR;
            end
         end
         S_VAR: begin
            // Read, absolute difference, square and accumulate, each step registered.
            if (idx_ff < rec_ff.kept_count) begin
               idx_in    = idx_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
            end
            d_vld_in  = rd_vld_ff;
            d_in      = (smp_rdata >= mean_ff) ? smp_rdata - mean_ff : mean_ff - smp_rdata;
            sq_vld_in = d_vld_ff;
            sq_in     = SQ_W'(d_ff) * SQ_W'(d_ff);
            if (sq_vld_ff) begin
               ss_in = ss_ff + SS_W'(sq_ff);
            end
            if (idx_ff == rec_ff.kept_count && !rd_vld_ff && !d_vld_ff && !sq_vld_ff) begin
               div_start    = 1'b1;
               div_dividend = ss_ff;
               div_divisor  = DIVISOR_W'(rec_ff.kept_count);
               state_in     = S_VDIV;
            end
         end
         S_VDIV: begin
            if (div_done) begin
               sqrt_start = 1'b1;
               state_in   = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sqrt_done) begin
               prod_in  = PROD_W'(sigma_ff) * PROD_W'(sqrt_root);
               state_in = S_BOUND;
            end
         end
         S_BOUND: begin
            rec_in.learned_low   = diff_sh[LOW_W-1:0];
            rec_in.learned_valid = 1'b1;
            rec_in.kept_count    = '0;
            state_in             = S_UPDATE;
         end
         S_UPDATE: begin
            occ_in = 1'b0;
            if (rec_ff.frame_count == window32 + FC_W'(1)) begin
               rec_in.kept_count = '0;
            end
            if (score_s > bound) begin
               if (rec_ff.normal_run != '1) begin
                  rec_in.normal_run = rec_ff.normal_run + RUN_W'(1);
               end
               if (rec_in.normal_run >= nlimit_ff) begin
                  rec_in.normal_run = '0;
                  rec_in.low_run    = '0;
               end
            end else begin
               if (rec_ff.low_run != '1) begin
                  rec_in.low_run = rec_ff.low_run + RUN_W'(1);
               end
               rec_in.normal_run = '0;
               occ_in = (rec_in.low_run >= olimit_ff);
            end
            // A backward time step never restarts calibration.
            if (!delta[TS_W-1] && delta > TS_W'(recalib_ff)) begin
               rec_in.frame_count = '0;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_occ_in   = occ_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         d_vld_ff     <= 1'b0;
         sq_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wb_ff        <= 1'b0;
         calib_ff     <= 16'd100;
         spacing_ff   <= 8'd10;
         nlimit_ff    <= 16'd25;
         olimit_ff    <= 16'd25;
         recalib_ff   <= 32'd3600000;
         initlow_ff   <= 32'd25600;
         sigma_ff     <= 12'd768;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rd_vld_ff    <= rd_vld_in;
         d_vld_ff     <= d_vld_in;
         sq_vld_ff    <= sq_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         wb_ff        <= (state_ff == S_UPDATE);
         if (csr_valid) begin
            case (csr_index)
               CSR_CALIB_FRAMES:     calib_ff   <= csr_wdata[15:0];
               CSR_SAMPLE_SPACING:   spacing_ff <= csr_wdata[7:0];
               CSR_NORMAL_RUN_LIMIT: nlimit_ff  <= csr_wdata[15:0];
               CSR_OCCL_RUN_LIMIT:   olimit_ff  <= csr_wdata[15:0];
               CSR_RECALIB_INTERVAL: recalib_ff <= csr_wdata;
               CSR_INITIAL_LOW:      initlow_ff <= csr_wdata;
               CSR_SIGMA:            sigma_ff   <= csr_wdata[SIGMA_W-1:0];
               default: begin
               end
            endcase
         end
      end
      cmd_ff     <= cmd_in;
      cam_ff     <= cam_in;
      score_ff   <= score_in;
      ts_ff      <= ts_in;
      rec_ff     <= rec_in;
      idx_ff     <= idx_in;
      d_ff       <= d_in;
      sq_ff      <= sq_in;
      sum_ff     <= sum_in;
      ss_ff      <= ss_in;
      mean_ff    <= mean_in;
      prod_ff    <= prod_in;
      occ_ff     <= occ_in;
      rsp_occ_ff <= rsp_occ_in;
   end

   assign st_we        = wb_ff;
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_occluded = rsp_occ_ff;

   // A new division is never started while the divider is still working.
   assert property (@(posedge clock) disable iff (reset) div_start |-> !div_busy)
      else $error("divider restarted while busy");

   // Kept scores are written only after the spacing check and below capacity.
   assert property (@(posedge clock) disable iff (reset)
      smp_we |-> (state_ff == S_MOD && rec_ff.kept_count < CNT_W'(MAX_SAMPLES)))
      else $error("sample store written out of place");

   // The camera record is written back only right after an update step.
   assert property (@(posedge clock) disable iff (reset)
      st_we |-> $past(state_ff) == S_UPDATE)
      else $error("state record written without update");

   // An accepted item is always followed by the record lookup.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == S_LOAD)
      else $error("accepted item not looked up");

endmodule
`default_nettype wire
